FILE: hdl/tdf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdf_pkg
// shared widths, constants and state type of the trial division factorizer
// ----------------------------------------------------------------------------
package tdf_pkg;

    localparam int VALUE_BITS   = 17;
    localparam int SIEVE_LIMIT  = 512;
    localparam int PRIME_STORE  = 128;
    localparam int MAX_RESULTS  = 6;
    localparam int MAP_AW       = $clog2(SIEVE_LIMIT);
    localparam int PL_AW        = $clog2(PRIME_STORE);
    localparam int PCNT_W       = PL_AW + 1;
    localparam int PRIME_W      = MAP_AW;
    localparam int EXP_W        = 5;
    localparam int IDX_W        = 3;
    localparam int BIT_CNT_W    = $clog2(VALUE_BITS + 1);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_SV_LOOK,
        ST_SV_TEST,
        ST_SV_RD,
        ST_SV_MARK,
        ST_SV_MOD,
        ST_IDLE,
        ST_FETCH,
        ST_SQ,
        ST_DIV,
        ST_CHECK,
        ST_EMIT,
        ST_WAIT
    } tdf_state_t;

endpackage

FILE: hdl/tdf_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdf_divider
// restoring bit-serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tdf_divider
    import tdf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [VALUE_BITS-1:0] divisor,
    output logic                  done,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [VALUE_BITS-1:0] remainder
);

    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [VALUE_BITS-1:0] dsr_reg, dsr_next;
    logic [BIT_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [VALUE_BITS:0]   trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[VALUE_BITS-1]};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = BIT_CNT_W'(VALUE_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // shift in next dividend bit, subtract when it fits
            if (trial >= {1'b0, dsr_reg}) begin
                rem_next = VALUE_BITS'(trial - {1'b0, dsr_reg});
                quo_next = {quo_reg[VALUE_BITS-2:0], 1'b1};
            end else begin
                rem_next = trial[VALUE_BITS-1:0];
                quo_next = {quo_reg[VALUE_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == BIT_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        cnt_reg <= cnt_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

FILE: hdl/trial_division_factorizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_factorizer
// prime factorization by trial division over a sieved prime table
// ----------------------------------------------------------------------------
// s_value is taken on an s_valid/s_ready beat; every distinct prime factor
// comes out as one m_ beat, ascending, with m_last_factor on the final one.
// A value of 0 or 1 gives one beat with m_no_factors set.
// After reset the bitmap is cleared and the linear sieve then runs: one
// bitmap access, a shift-add product and a bit-serial modulo per marked
// composite; s_ready stays low until it has finished.
// Each trial prime takes a fetch, a bit-serial square and a bit-serial
// division; a prime that divides is divided again until it no longer
// does, and each result beat takes an emit step. A large prime walks all
// 72 primes up to its square root through the single shared divider.
// Results sit in an output register; while m_ready is low the block holds
// that beat, and it stops when its next beat is due or before it takes a
// new value. One item is worked on at a time.
// ----------------------------------------------------------------------------
module trial_division_factorizer
    import tdf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [16:0]           s_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [16:0]           m_prime_factor,
    output logic [4:0]            m_exponent,
    output logic [2:0]            m_factor_index,
    output logic                  m_last_factor,
    output logic                  m_no_factors
);

    logic                  comp_map [SIEVE_LIMIT];
    logic [PRIME_W-1:0]    prime_mem [PRIME_STORE];

    tdf_state_t state_reg, state_next;

    logic [MAP_AW:0]       i_reg, i_next;          // sieve outer index / clear address
    logic [PCNT_W-1:0]     j_reg, j_next;          // prime table index
    logic [PCNT_W-1:0]     total_reg, total_next;
    logic                  map_rd_reg;
    logic [PRIME_W-1:0]    p_rd_reg;
    logic [PRIME_W-1:0]    p_reg, p_next;
    logic [VALUE_BITS-1:0] x_reg, x_next;
    logic [2*PRIME_W-1:0]  acc_reg, acc_next;      // shift-add product
    logic [PRIME_W-1:0]    mcand_reg, mcand_next;
    logic [PRIME_W-1:0]    mplier_reg, mplier_next;
    logic [BIT_CNT_W-1:0]  mcnt_reg, mcnt_next;
    logic [EXP_W-1:0]      e_reg, e_next;
    logic [IDX_W-1:0]      cnt_reg, cnt_next;
    logic                  sv_mode_reg, sv_mode_next; // SQ state used by sieve product
    logic                  pend_reg, pend_next;    // factor with e>0 pending

    logic                  mv_reg, mv_next;
    logic [VALUE_BITS-1:0] mf_reg, mf_next;
    logic [EXP_W-1:0]      me_reg, me_next;
    logic [IDX_W-1:0]      mi_reg, mi_next;
    logic                  ml_reg, ml_next;
    logic                  mn_reg, mn_next;
    logic                  fin_reg, fin_next;      // beat in register ends item

    logic                  map_we;
    logic [MAP_AW-1:0]     map_wa;
    logic                  map_wd;
    logic [MAP_AW-1:0]     map_ra;
    logic                  pl_we;
    logic [PL_AW-1:0]      pl_wa;
    logic [PL_AW-1:0]      pl_ra;

    logic                  div_start;
    logic [VALUE_BITS-1:0] div_a, div_b;
    logic                  div_done;
    logic [VALUE_BITS-1:0] div_q, div_r;

    logic                  sq_gt_x;                // square of trial prime above value

    tdf_divider u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_ff @(posedge aclk) begin
        if (map_we) comp_map[map_wa] <= map_wd;
        map_rd_reg <= comp_map[map_ra];
        if (pl_we) prime_mem[pl_wa] <= i_reg[PRIME_W-1:0];
        p_rd_reg <= prime_mem[pl_ra];
    end

    logic out_free;
    assign out_free = !mv_reg || m_ready;

    // full-width compare, the square can exceed the value width
    assign sq_gt_x = 32'(acc_reg) > 32'(x_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:   if (i_reg == (MAP_AW+1)'(SIEVE_LIMIT - 1)) state_next = ST_SV_LOOK;
            ST_SV_LOOK: state_next = (i_reg == (MAP_AW+1)'(SIEVE_LIMIT)) ? ST_IDLE : ST_SV_TEST;
            ST_SV_TEST: state_next = ST_SV_RD;
            ST_SV_RD:   state_next = (j_reg >= total_next) ? ST_SV_LOOK : ST_SQ;
            ST_SV_MARK: state_next = ST_SV_MOD;
            ST_SV_MOD:  if (div_done) state_next =
                            (div_r == '0 || j_reg + 1'b1 >= total_reg) ? ST_SV_LOOK : ST_SV_RD;
            ST_IDLE:    if (s_valid) state_next = ST_FETCH;
            ST_FETCH:   state_next = ST_SQ;
            ST_SQ: begin
                if (mcnt_reg == '0) begin
                    if (sv_mode_reg)
                        state_next = ({1'b0, acc_reg} >= (2*PRIME_W+1)'(SIEVE_LIMIT))
                                     ? ST_SV_LOOK : ST_SV_MARK;
                    else
                        state_next = (p_reg < PRIME_W'(2) || sq_gt_x) ? ST_CHECK : ST_DIV;
                end
            end
            ST_DIV:     if (div_done) state_next = (div_r == '0) ? ST_DIV :
                            (pend_reg ? ST_EMIT : ST_FETCH);
            ST_CHECK:   state_next = ST_EMIT;
            ST_EMIT:    if (out_free) state_next = fin_next ? ST_WAIT : ST_FETCH;
            ST_WAIT:    if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
        if (state_reg == ST_DIV && div_done && div_r != '0 && !pend_reg &&
            j_reg >= total_reg)
            state_next = ST_CHECK;
    end

    // datapath and outputs
    always_comb begin
        i_next = i_reg;  j_next = j_reg;  total_next = total_reg;
        p_next = p_reg;  x_next = x_reg;  acc_next = acc_reg;
        mcand_next = mcand_reg;  mplier_next = mplier_reg;  mcnt_next = mcnt_reg;
        e_next = e_reg;  cnt_next = cnt_reg;  sv_mode_next = sv_mode_reg;
        pend_next = pend_reg;
        mv_next = mv_reg && !m_ready;
        mf_next = mf_reg; me_next = me_reg; mi_next = mi_reg;
        ml_next = ml_reg; mn_next = mn_reg; fin_next = fin_reg;
        map_we = 1'b0; map_wa = i_reg[MAP_AW-1:0]; map_wd = 1'b0;
        map_ra = i_reg[MAP_AW-1:0];
        pl_we = 1'b0; pl_wa = total_reg[PL_AW-1:0]; pl_ra = j_reg[PL_AW-1:0];
        div_start = 1'b0; div_a = x_reg; div_b = VALUE_BITS'(p_reg);
        s_ready = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                map_we = 1'b1;
                i_next = (i_reg == (MAP_AW+1)'(SIEVE_LIMIT - 1)) ? (MAP_AW+1)'(2) : i_reg + 1'b1;
                total_next = '0;
            end
            ST_SV_LOOK: j_next = '0;      // map read of i issued here
            ST_SV_TEST: begin
                if (!map_rd_reg && total_reg < PCNT_W'(PRIME_STORE)) begin
                    pl_we = 1'b1;
                    total_next = total_reg + 1'b1;
                end
            end
            ST_SV_RD: begin
                // read of prime j issued here arrives at SQ entry
                if (j_reg < total_next) begin
                    mcnt_next = BIT_CNT_W'(PRIME_W);
                    sv_mode_next = 1'b1;
                end
            end
            ST_SQ: begin
                if (mcnt_reg != '0) begin
                    if (mcnt_reg == BIT_CNT_W'(PRIME_W)) begin
                        p_next = p_rd_reg;
                        mcand_next = p_rd_reg;
                        mplier_next = sv_mode_reg ? i_reg[PRIME_W-1:0] : p_rd_reg;
                        acc_next = '0;
                        mcnt_next = mcnt_reg - 1'b1;
                        if (sv_mode_reg) begin
                            mplier_next = i_reg[PRIME_W-1:0];
                        end
                        // first shift-add step folded in
                        acc_next = {PRIME_W'(0), (sv_mode_reg ? i_reg[0] : p_rd_reg[0])
                                    ? p_rd_reg : PRIME_W'(0)};
                        mcand_next = p_rd_reg;
                        mplier_next = (sv_mode_reg ? i_reg[PRIME_W-1:0] : p_rd_reg) >> 1;
                    end else begin
                        acc_next = acc_reg + (mplier_reg[0]
                            ? ((2*PRIME_W)'(mcand_reg) << (PRIME_W - mcnt_reg)) : '0);
                        mplier_next = mplier_reg >> 1;
                        mcnt_next = mcnt_reg - 1'b1;
                    end
                end else if (sv_mode_reg) begin
                    // product past the bitmap ends the pass for this i
                    if ({1'b0, acc_reg} >= (2*PRIME_W+1)'(SIEVE_LIMIT))
                        i_next = i_reg + 1'b1;
                end else begin
                    if (!(p_reg < PRIME_W'(2) || sq_gt_x)) begin
                        div_start = 1'b1;
                        e_next = '0;
                        pend_next = 1'b0;
                    end
                end
            end
            ST_SV_MARK: begin
                map_we = 1'b1;
                map_wa = acc_reg[MAP_AW-1:0];
                map_wd = 1'b1;
                div_start = 1'b1;
                div_a = VALUE_BITS'(i_reg);
            end
            ST_SV_MOD: begin
                if (div_done) begin
                    j_next = j_reg + 1'b1;
                    pl_ra = PL_AW'(j_reg + 1'b1);
                    if (div_r == '0 || j_reg + 1'b1 >= total_reg)
                        i_next = i_reg + 1'b1;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                x_next = VALUE_BITS'(s_value);
                j_next = '0;
                cnt_next = '0;
                sv_mode_next = 1'b0;
            end
            ST_FETCH: begin
                mcnt_next = BIT_CNT_W'(PRIME_W);
                if (x_reg <= VALUE_BITS'(1) || j_reg >= total_reg) mcnt_next = '0;
                if (x_reg <= VALUE_BITS'(1)) acc_next = '1;
                else if (j_reg >= total_reg) begin
                    acc_next = '1;
                    p_next = PRIME_W'(2);
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    if (div_r == '0) begin
                        x_next = div_q;
                        e_next = e_reg + 1'b1;
                        pend_next = 1'b1;
                        div_start = 1'b1;
                        div_a = div_q;
                    end else begin
                        j_next = j_reg + 1'b1;
                        pl_ra = PL_AW'(j_reg + 1'b1);
                    end
                end
            end
            ST_CHECK: begin
                // remainder stage: value > 1 becomes final prime
                pend_next = 1'b0;
                if (x_reg > VALUE_BITS'(1)) begin
                    e_next = EXP_W'(1);
                    p_next = '0;
                end else e_next = '0;
            end
            ST_EMIT: begin
                if (out_free) begin
                    mv_next = 1'b1;
                    mn_next = 1'b0;
                    mi_next = cnt_reg;
                    cnt_next = cnt_reg + 1'b1;
                    if (!pend_reg && e_reg == EXP_W'(1) && p_reg == '0) begin
                        mf_next = x_reg; me_next = e_reg; fin_next = 1'b1;
                    end else if (!pend_reg) begin
                        // nothing left: value was zero or one
                        mf_next = '0; me_next = '0; mn_next = 1'b1; fin_next = 1'b1;
                    end else begin
                        // prime index already moved on when the division failed
                        mf_next = VALUE_BITS'(p_reg); me_next = e_reg;
                        fin_next = (x_reg == VALUE_BITS'(1)) ||
                                   (cnt_reg == IDX_W'(MAX_RESULTS - 1));
                        pend_next = 1'b0;
                    end
                    ml_next = fin_next;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        i_reg <= i_next; j_reg <= j_next; p_reg <= p_next; x_reg <= x_next;
        acc_reg <= acc_next; mcand_reg <= mcand_next; mplier_reg <= mplier_next;
        e_reg <= e_next; cnt_reg <= cnt_next; pend_reg <= pend_next;
        mf_reg <= mf_next; me_reg <= me_next; mi_reg <= mi_next;
        ml_reg <= ml_next; mn_reg <= mn_next; fin_reg <= fin_next;
        sv_mode_reg <= sv_mode_next;
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            i_reg     <= '0;
            total_reg <= '0;
            mcnt_reg  <= '0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            total_reg <= total_next;
            mcnt_reg  <= mcnt_next;
            mv_reg    <= mv_next;
        end
    end

    assign m_valid        = mv_reg;
    assign m_prime_factor = mf_reg;
    assign m_exponent     = me_reg;
    assign m_factor_index = mi_reg;
    assign m_last_factor  = ml_reg;
    assign m_no_factors   = mn_reg;

endmodule

FILE: hdl/tdf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdf_checker
// port-level checks on the factorizer result stream
// ----------------------------------------------------------------------------
module tdf_checker
    import tdf_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [16:0] m_prime_factor,
    input logic [4:0]  m_exponent,
    input logic [2:0]  m_factor_index,
    input logic        m_last_factor,
    input logic        m_no_factors
);

    // a stalled beat holds valid and its prime factor
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_prime_factor))
        else $error("result beat changed while stalled");

    // no-factor beat is alone and last
    a_none: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_no_factors |-> m_last_factor && m_factor_index == 3'd0)
        else $error("bad no-factor beat");

    // every real factor has a nonzero exponent and is above one
    a_exp: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_no_factors |-> m_exponent != 5'd0 && m_prime_factor > 17'd1)
        else $error("bad factor beat");

    // no new item taken while a result is waiting
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken during output");

endmodule

bind trial_division_factorizer tdf_checker u_tdf_checker (.*);

FILE: sim/trial_division_factorizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trial_division_factorizer_tb
// self-checking bench for the trial division factorizer
// ----------------------------------------------------------------------------
// Values are queued by an initial block and sent in random bursts; each value
// is factored in the bench by trial division over primes found with its own
// sieve, and every result beat is compared with the oldest expected factor.
// The receiver stalls on its own pattern, with one long hold-off so that the
// block backs up and stops taking values.
// ----------------------------------------------------------------------------
module trial_division_factorizer_tb
    import tdf_pkg::*;
();

    typedef struct packed {
        logic [16:0] prime_factor;
        logic [4:0]  exponent;
        logic [2:0]  factor_index;
        logic        last_factor;
        logic        no_factors;
    } factor_beat_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [16:0] s_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [16:0] m_prime_factor;
    logic [4:0]  m_exponent;
    logic [2:0]  m_factor_index;
    logic        m_last_factor;
    logic        m_no_factors;

    logic [16:0]  value_queue[$];
    factor_beat_t factor_queue[$];
    int unsigned  primes[$];
    int           fail_count = 0;
    bit           all_sent = 1'b0;
    bit           hold_off = 1'b0;
    int           gap_left = 0;
    int           burst_left = 0;

    always #5 aclk = ~aclk;

    trial_division_factorizer dut (.*);

    // linear sieve below SIEVE_LIMIT, store capped at PRIME_STORE
    function automatic void build_primes();
        bit composite[SIEVE_LIMIT];
        int unsigned m;
        for (int i = 2; i < SIEVE_LIMIT; i++) begin
            if (!composite[i] && primes.size() < PRIME_STORE) primes.push_back(i);
            foreach (primes[j]) begin
                m = primes[j] * i;
                if (m >= SIEVE_LIMIT) break;
                composite[m] = 1'b1;
                if (i % primes[j] == 0) break;
            end
        end
    endfunction

    function automatic void factorize(logic [16:0] v);
        int unsigned x = v;
        int unsigned fac[$];
        int unsigned ex[$];
        int unsigned e;
        factor_beat_t b;
        if (x <= 1) begin
            b = '{17'd0, 5'd0, 3'd0, 1'b1, 1'b1};
            factor_queue.push_back(b);
            return;
        end
        foreach (primes[i]) begin
            if (primes[i] * primes[i] > x) break;
            if (x % primes[i] == 0) begin
                e = 0;
                while (x % primes[i] == 0) begin
                    x /= primes[i];
                    e++;
                end
                if (fac.size() < MAX_RESULTS) begin
                    fac.push_back(primes[i]);
                    ex.push_back(e);
                end
            end
        end
        if (x > 1 && fac.size() < MAX_RESULTS) begin
            fac.push_back(x);
            ex.push_back(1);
        end
        foreach (fac[k]) begin
            b.prime_factor = 17'(fac[k]);
            b.exponent     = 5'(ex[k]);
            b.factor_index = 3'(k);
            b.last_factor  = (k == int'(fac.size()) - 1);
            b.no_factors   = 1'b0;
            factor_queue.push_back(b);
        end
    endfunction

    // random value with a small-prime heavy build so exponents and counts vary
    function automatic logic [16:0] pick_value();
        int unsigned v;
        int unsigned p;
        case ($urandom_range(0, 3))
            0: return 17'($urandom_range(1, 131071));
            1: return 17'($urandom_range(1, 600));
            default: begin
                v = 1;
                repeat ($urandom_range(1, 12)) begin
                    p = primes[$urandom_range(0, 9)];
                    if (v * p <= 131071) v *= p;
                end
                if ($urandom_range(0, 1) && v * 509 <= 131071) v *= 509;
                return 17'(v);
            end
        endcase
    endfunction

    initial begin
        logic [16:0] directed[$];
        directed = '{17'd1, 17'd0, 17'd2, 17'd3, 17'd131071, 17'd131071,
            17'd65536, 17'd131070, 17'd30030, 17'd117294, 17'd130049,
            17'd509, 17'd130321, 17'd4, 17'd59049, 17'd100000, 17'd510, 17'd1024, 17'd2310,
            17'd131000, 17'd130937, 17'd97, 17'd1};
        build_primes();
        foreach (directed[i]) value_queue.push_back(directed[i]);
        value_queue.push_back(17'h1FFFF);
        value_queue.push_back(17'h10000);
        repeat (435) value_queue.push_back(pick_value());
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // driver
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) factorize(s_value);
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid <= 1'b0;
                end else if (value_queue.size() > 0) begin
                    s_valid <= 1'b1;
                    s_value <= value_queue.pop_front();
                    if (burst_left > 1) begin
                        burst_left <= burst_left - 1;
                    end else begin
                        burst_left <= $urandom_range(1, 12);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 600);
                    end
                end else begin
                    s_valid  <= 1'b0;
                    all_sent <= 1'b1;
                end
            end
        end
    end

    // receiver stall pattern plus one long hold-off once the sieve is done
    initial begin
        wait (aresetn);
        repeat (40000) @(posedge aclk);
        hold_off = 1'b1;
        repeat (30000) @(posedge aclk);
        hold_off = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn)
            m_ready <= !hold_off && ($urandom_range(0, 9) < 7 || $urandom_range(0, 1));
    end

    // monitor
    always @(posedge aclk) begin
        factor_beat_t want;
        if (aresetn && m_valid && m_ready) begin
            if (factor_queue.size() == 0) begin
                $error("result beat with no value pending: factor %0d", m_prime_factor);
                fail_count++;
            end else begin
                want = factor_queue.pop_front();
                if (m_prime_factor !== want.prime_factor) begin
                    $error("prime_factor expected %0d got %0d", want.prime_factor, m_prime_factor);
                    fail_count++;
                end
                if (m_exponent !== want.exponent) begin
                    $error("exponent expected %0d got %0d", want.exponent, m_exponent);
                    fail_count++;
                end
                if (m_factor_index !== want.factor_index) begin
                    $error("factor_index expected %0d got %0d", want.factor_index, m_factor_index);
                    fail_count++;
                end
                if (m_last_factor !== want.last_factor) begin
                    $error("last_factor expected %0d got %0d", want.last_factor, m_last_factor);
                    fail_count++;
                end
                if (m_no_factors !== want.no_factors) begin
                    $error("no_factors expected %0d got %0d", want.no_factors, m_no_factors);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        wait (all_sent && factor_queue.size() == 0);
        repeat (3000) @(posedge aclk);
        if (fail_count == 0 && factor_queue.size() == 0) begin
            $display("** trial_division_factorizer: PASSED **");
        end else begin
            $display("** trial_division_factorizer: FAILED **");
        end
        $finish;
    end

    initial begin
        #100ms;
        $display("** trial_division_factorizer: FAILED **");
        $finish;
    end

endmodule
